>>> design/flrt_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants, register indexes and controller/datapath structs
package flrt_pkg;

    localparam int SLOTS_DEFAULT = 30;
    localparam int LEVEL_FULL    = 1023;

    localparam int STAMP_W = 32;
    localparam int FREQ_W  = 24;
    localparam int HOLD_W  = 16;
    localparam int LEVEL_W = 10;

    localparam int NUM_W = 2 * FREQ_W + LEVEL_W;
    localparam int DEN_W = 2 * FREQ_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF   = 2'd2;

    localparam logic [HOLD_W-1:0]  HOLD_RESET    = 16'd10;
    localparam logic [STAMP_W-1:0] EARLY_SECONDS = 32'd3;

    typedef struct packed {
        logic accept;
        logic scan_clear;
        logic scan_run;
        logic recall;
        logic write_slot;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic calib_ok;
        logic store_in;
        logic div_done;
        logic scan_done;
    } status_t;

endpackage

>>> design/flrt_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for items, results and register writes
interface flrt_item_if;
    logic                         valid;
    logic                         ready;
    logic [flrt_pkg::STAMP_W-1:0] now_seconds;
    logic [flrt_pkg::FREQ_W-1:0]  frequency;
    logic                         reading_normal;

    modport source (output valid, output now_seconds, output frequency,
                    output reading_normal, input ready);
    modport sink (input valid, input now_seconds, input frequency,
                  input reading_normal, output ready);
endinterface

interface flrt_result_if;
    logic                         valid;
    logic                         ready;
    logic [flrt_pkg::LEVEL_W-1:0] direct_level;
    logic [flrt_pkg::LEVEL_W-1:0] held_level;
    logic                         level_recalled;
    logic                         calibration_valid;

    modport source (output valid, output direct_level, output held_level,
                    output level_recalled, output calibration_valid, input ready);
    modport sink (input valid, input direct_level, input held_level,
                  input level_recalled, input calibration_valid, output ready);
endinterface

interface flrt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [flrt_pkg::CFG_IDX_W-1:0]  index;
    logic [flrt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/flrt_div.sv
`timescale 1ns / 1ps
// multi-cycle level quotient: two multiplies, a scale, then one quotient bit per cycle
module flrt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [flrt_pkg::FREQ_W-1:0]  empty_freq,
    input  logic [flrt_pkg::FREQ_W-1:0]  full_freq,
    input  logic [flrt_pkg::FREQ_W-1:0]  freq,
    output logic [flrt_pkg::LEVEL_W-1:0] quot,
    output logic                         done
);

    localparam int QUOT_W = flrt_pkg::LEVEL_W;
    localparam int STEP_W = $clog2(QUOT_W + 2);
    localparam logic [STEP_W-1:0] STEP_MUL   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_SCALE = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(QUOT_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [flrt_pkg::DEN_W-1:0]   p1_reg;
    logic [flrt_pkg::DEN_W-1:0]   p2_reg;
    logic [flrt_pkg::NUM_W-1:0]   rem_reg;
    logic [flrt_pkg::NUM_W-1:0]   dsh_reg;
    logic [QUOT_W-1:0]            quot_reg;

    logic [flrt_pkg::FREQ_W-1:0]  diff_num;
    logic [flrt_pkg::FREQ_W-1:0]  diff_den;
    logic                         fits;

    assign diff_num = empty_freq - freq;
    assign diff_den = empty_freq - full_freq;
    assign fits     = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_MUL;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (step_reg == STEP_MUL)
            begin
                p1_reg <= flrt_pkg::DEN_W'(diff_num) * flrt_pkg::DEN_W'(full_freq);
                p2_reg <= flrt_pkg::DEN_W'(diff_den) * flrt_pkg::DEN_W'(freq);
            end
            else if (step_reg == STEP_SCALE)
            begin
                rem_reg  <= flrt_pkg::NUM_W'(p1_reg) * flrt_pkg::NUM_W'(flrt_pkg::LEVEL_FULL);
                dsh_reg  <= flrt_pkg::NUM_W'(p2_reg) << (QUOT_W - 1);
                quot_reg <= '0;
            end
            else
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quot_reg <= {quot_reg[QUOT_W-2:0], fits};
                dsh_reg  <= dsh_reg >> 1;
            end
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

>>> design/flrt_ctrl.sv
`timescale 1ns / 1ps
// sequencer: item accept, oldest-slot scan, slot write, recall scan, result hand-off
module flrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  flrt_pkg::status_t status,
    output flrt_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLDEST,
        ST_WRITE,
        ST_RECALL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   load_out;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign load_out   = (state_reg == ST_FINISH) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!status.calib_ok)
                        state_next = ST_FINISH;
                    else if (status.store_in)
                        state_next = ST_OLDEST;
                    else
                        state_next = ST_RECALL;
                end
            end
            ST_OLDEST:
            begin
                if (status.scan_done && status.div_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_RECALL;
            end
            ST_RECALL:
            begin
                if (status.scan_done && status.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd.accept     = accept;
        cmd.scan_clear = accept || (state_reg == ST_WRITE);
        cmd.scan_run   = (state_reg == ST_OLDEST) || (state_reg == ST_RECALL);
        cmd.recall     = (state_reg == ST_RECALL);
        cmd.write_slot = (state_reg == ST_WRITE);
        cmd.load_out   = load_out;
    end

    assign result_valid = out_valid_reg;

endmodule

>>> design/flrt_dp.sv
`timescale 1ns / 1ps
// datapath: registers, slot memory with valid bits, scan engine, level quotient
module flrt_dp #(
    parameter int SLOTS = flrt_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flrt_pkg::cmd_t                  cmd,
    output flrt_pkg::status_t               status,
    input  logic [flrt_pkg::STAMP_W-1:0]    item_now,
    input  logic [flrt_pkg::FREQ_W-1:0]     item_freq,
    input  logic                            item_normal,
    input  logic                            cfg_valid,
    input  logic [flrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flrt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [flrt_pkg::LEVEL_W-1:0]    direct_level,
    output logic [flrt_pkg::LEVEL_W-1:0]    held_level,
    output logic                            level_recalled,
    output logic                            calibration_valid
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STAMP_W = flrt_pkg::STAMP_W;
    localparam int LEVEL_W = flrt_pkg::LEVEL_W;
    localparam int ENTRY_W = STAMP_W + LEVEL_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // configuration
    logic [flrt_pkg::FREQ_W-1:0] full_reg;
    logic [flrt_pkg::FREQ_W-1:0] empty_reg;
    logic [flrt_pkg::HOLD_W-1:0] hold_reg;
    logic                        calib_ok;

    // item
    logic [STAMP_W-1:0]          now_reg;
    logic [flrt_pkg::FREQ_W-1:0] freq_reg;
    logic                        normal_reg;
    logic                        zero_reg;
    logic                        max_reg;
    logic                        item_calib_reg;

    // persistent state
    logic                        prev_normal_reg;
    logic [STAMP_W-1:0]          recovery_reg;
    logic [LEVEL_W-1:0]          reported_reg;
    logic [LEVEL_W-1:0]          last_direct_reg;
    logic [SLOTS-1:0]            slot_valid_reg;

    // slot memory
    logic [ENTRY_W-1:0]          mem [SLOTS];
    logic [ENTRY_W-1:0]          mem_q_reg;

    // scan engine
    logic [IDX_W-1:0]            addr_reg;
    logic                        issue_done_reg;
    logic                        rd_pend_reg;
    logic                        rd_mode_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic [IDX_W-1:0]            old_pick_reg;
    logic [STAMP_W-1:0]          old_best_reg;
    logic                        empty_hit_reg;
    logic                        rec_found_reg;
    logic [STAMP_W-1:0]          rec_best_reg;
    logic [LEVEL_W-1:0]          rec_level_reg;

    logic [STAMP_W-1:0]          recovery_new;
    logic [STAMP_W-1:0]          elapsed;
    logic                        mem_re;
    logic [STAMP_W-1:0]          q_stamp;
    logic [LEVEL_W-1:0]          q_level;
    logic                        eligible;
    logic                        clear_hit;
    logic [LEVEL_W-1:0]          div_q;
    logic                        div_done;
    logic [LEVEL_W-1:0]          direct;

    assign calib_ok = (full_reg != '0) && (empty_reg != '0) && (empty_reg > full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= '0;
            empty_reg <= '0;
            hold_reg  <= flrt_pkg::HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                flrt_pkg::CFG_FULL_FREQ:  full_reg  <= cfg_data;
                flrt_pkg::CFG_EMPTY_FREQ: empty_reg <= cfg_data;
                flrt_pkg::CFG_HOLD_OFF:   hold_reg  <= cfg_data[flrt_pkg::HOLD_W-1:0];
                default:                  ;
            endcase
        end
    end

    // recovery point as seen by this item, and the store decision
    assign recovery_new = (!prev_normal_reg && item_normal) ? item_now : recovery_reg;
    assign elapsed      = item_now - recovery_new;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg    <= item_now;
            freq_reg   <= item_freq;
            normal_reg <= item_normal;
            zero_reg   <= (item_freq == '0) || (item_freq >= empty_reg);
            max_reg    <= (item_freq <= full_reg);
        end
    end

    flrt_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.accept && calib_ok),
        .empty_freq (empty_reg),
        .full_freq  (full_reg),
        .freq       (freq_reg),
        .quot       (div_q),
        .done       (div_done)
    );

    always_comb
    begin
        if (zero_reg)
            direct = '0;
        else if (max_reg)
            direct = LEVEL_W'(flrt_pkg::LEVEL_FULL);
        else
            direct = div_q;
    end

    // scan engine: one read issued per cycle, its data checked in the next cycle
    assign mem_re = cmd.scan_run && !issue_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rd_mode_reg    <= 1'b0;
            rd_idx_reg     <= '0;
        end
        else if (cmd.scan_clear)
        begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            rd_pend_reg <= !issue_done_reg;
            rd_idx_reg  <= addr_reg;
            rd_mode_reg <= cmd.recall;
            if (!issue_done_reg)
            begin
                if (addr_reg == LAST_IDX)
                    issue_done_reg <= 1'b1;
                else
                    addr_reg <= addr_reg + IDX_W'(1);
            end
        end
        else
        begin
            rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_slot)
            mem[old_pick_reg] <= {now_reg, direct};
        if (mem_re)
            mem_q_reg <= mem[addr_reg];
    end

    assign q_stamp   = slot_valid_reg[rd_idx_reg] ? mem_q_reg[ENTRY_W-1:LEVEL_W] : '0;
    assign q_level   = mem_q_reg[LEVEL_W-1:0];
    assign eligible  = ((STAMP_W + 1)'(q_stamp) + (STAMP_W + 1)'(hold_reg))
                       < (STAMP_W + 1)'(now_reg);
    assign clear_hit = rd_pend_reg && rd_mode_reg && (q_stamp != '0) && !eligible
                       && !normal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_pick_reg  <= '0;
            old_best_reg  <= '1;
            empty_hit_reg <= 1'b0;
            rec_found_reg <= 1'b0;
            rec_best_reg  <= '0;
            rec_level_reg <= '0;
        end
        else if (cmd.scan_clear)
        begin
            old_pick_reg  <= '0;
            old_best_reg  <= '1;
            empty_hit_reg <= 1'b0;
            rec_found_reg <= 1'b0;
            rec_best_reg  <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (!rd_mode_reg)
            begin
                // first empty slot, else lowest stamp with lowest index on ties
                if (!empty_hit_reg)
                begin
                    if (q_stamp == '0)
                    begin
                        old_pick_reg  <= rd_idx_reg;
                        empty_hit_reg <= 1'b1;
                    end
                    else if (q_stamp < old_best_reg)
                    begin
                        old_pick_reg <= rd_idx_reg;
                        old_best_reg <= q_stamp;
                    end
                end
            end
            else if ((q_stamp != '0) && eligible && (q_level != '0)
                     && (q_stamp > rec_best_reg))
            begin
                rec_found_reg <= 1'b1;
                rec_best_reg  <= q_stamp;
                rec_level_reg <= q_level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            if (cmd.write_slot)
                slot_valid_reg[old_pick_reg] <= 1'b1;
            if (clear_hit)
                slot_valid_reg[rd_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_calib_reg  <= 1'b0;
            prev_normal_reg <= 1'b1;
            recovery_reg    <= '0;
            reported_reg    <= '0;
            last_direct_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                item_calib_reg <= calib_ok;
                if (calib_ok)
                begin
                    prev_normal_reg <= item_normal;
                    recovery_reg    <= recovery_new;
                end
            end
            if (cmd.load_out && item_calib_reg)
            begin
                last_direct_reg <= direct;
                if (rec_found_reg)
                    reported_reg <= rec_level_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            direct_level      <= item_calib_reg ? direct : last_direct_reg;
            held_level        <= (item_calib_reg && rec_found_reg) ? rec_level_reg
                                                                   : reported_reg;
            level_recalled    <= item_calib_reg && rec_found_reg;
            calibration_valid <= item_calib_reg;
        end
    end

    assign status.calib_ok  = calib_ok;
    assign status.store_in  = item_normal
                              && (((recovery_new == '0) && (item_now >= flrt_pkg::EARLY_SECONDS))
                                  || (elapsed >= STAMP_W'(hold_reg)));
    assign status.div_done  = div_done;
    assign status.scan_done = issue_done_reg && !rd_pend_reg;

endmodule

>>> design/fuel_level_recall_table.sv
`timescale 1ns / 1ps
// top level of the fuel level recall table
// an item with unusable calibration goes straight to the result hand-off;
// otherwise a recall scan runs alone without a slot write, and an oldest-slot scan, the write
// and a recall scan run with one (the quotient runs beside the first scan and may set its end)
// throughput: one item at a time, set by the serial scans over the slot memory, two with a slot write
// reset: asynchronous, active low; slot valid bits clear at once, no clearing pass
module fuel_level_recall_table #(
    parameter int SLOTS = flrt_pkg::SLOTS_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    flrt_item_if.sink     item,
    flrt_result_if.source result,
    flrt_cfg_if.sink      cfg
);

    flrt_pkg::cmd_t    cmd;
    flrt_pkg::status_t status;

    assign cfg.ready = 1'b1;

    flrt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    flrt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .item_now          (item.now_seconds),
        .item_freq         (item.frequency),
        .item_normal       (item.reading_normal),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .direct_level      (result.direct_level),
        .held_level        (result.held_level),
        .level_recalled    (result.level_recalled),
        .calibration_valid (result.calibration_valid)
    );

endmodule

>>> design/flrt_chk.sv
`timescale 1ns / 1ps
// port-level checker for the fuel level recall table, bound to the top level
module flrt_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [flrt_pkg::LEVEL_W-1:0] direct_level,
    input logic [flrt_pkg::LEVEL_W-1:0] held_level,
    input logic                         level_recalled,
    input logic                         calibration_valid
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(direct_level)
            && $stable(held_level) && $stable(level_recalled) && $stable(calibration_valid))
        else $error("stalled result changed");

    // a recall only comes with usable calibration and a nonzero level
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && level_recalled |-> calibration_valid && (held_level != '0))
        else $error("recall without calibration or with zero level");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while one is in work");

    // no result shows up in the cycle right after a transfer into an empty output
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
        else $error("result appeared too early");

endmodule

bind fuel_level_recall_table flrt_chk u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .direct_level      (result.direct_level),
    .held_level        (result.held_level),
    .level_recalled    (result.level_recalled),
    .calibration_valid (result.calibration_valid)
);
